// ===== design/kwmh_pkg.sv =====
// Shared types, codes and the entry ordering for the k-way merge heap core.
`default_nettype none
package kwmh_pkg;

  localparam int VALUE_BITS = 32;
  localparam int LANE_BITS  = 4;
  localparam int LANES_DEF  = 16;
  localparam int ENTRY_BITS = VALUE_BITS + LANE_BITS;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_POP    = 1'b1;

  localparam logic [1:0] STAT_INSERTED  = 2'd0;
  localparam logic [1:0] STAT_POPPED    = 2'd1;
  localparam logic [1:0] STAT_POP_EMPTY = 2'd2;
  localparam logic [1:0] STAT_FULL_DROP = 2'd3;

  typedef struct packed {
    logic                         func;
    logic signed [VALUE_BITS-1:0] key_value;
    logic [LANE_BITS-1:0]         source_lane;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] min_value;
    logic [LANE_BITS-1:0]         min_lane;
    logic [1:0]                   status;
    logic                         queue_empty;
  } out_word_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [LANE_BITS-1:0]         lane;
  } entry_t;

  // a leaves before b: smaller value, ties to the lower lane
  function automatic logic entry_before(entry_t a, entry_t b);
    logic lt;
    lt = (a.value < b.value) || ((a.value == b.value) && (a.lane < b.lane));
    return lt;
  endfunction

endpackage
`default_nettype wire

// ===== design/kwmh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kwmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/k_way_merge_min_heap_core.sv =====
// Min-priority queue for a k-way merge: sequencer, one shared compare unit, entry RAM.
// Words are taken only in ST_IDLE; an output stall holds ST_RESP. Insert, or empty pop:
// ST_RESP loads the result. Pop: ST_SCAN reads each held entry, then ST_RESP; the single
// RAM read port feeding the shared comparator scans one entry per cycle.
// Synchronous active-high reset empties the queue and drops any pending result;
// entry RAM contents are not cleared, only entries below the count are ever used.
`default_nettype none
module k_way_merge_min_heap_core
  import kwmh_pkg::*;
#(
  parameter int LANES = LANES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_data
);

  localparam int AW = $clog2(LANES);
  localparam int CW = $clog2(LANES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(LANES);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // ready for a word
  localparam logic [1:0] ST_SCAN = 2'd1;  // one entry per cycle through the comparator
  localparam logic [1:0] ST_RESP = 2'd2;  // result waits for the output register

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic [AW-1:0] rd_idx;    // entry whose data arrives from the RAM this cycle
  entry_t        best;
  logic [AW-1:0] best_idx;
  out_word_t     res;

  logic                  in_take;
  logic                  is_insert;
  logic                  full;
  entry_t                cand;
  logic                  take_cand;
  entry_t                best_cur;
  logic [AW-1:0]         best_idx_cur;
  logic                  scan_last;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ENTRY_BITS-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [ENTRY_BITS-1:0] ram_rdata;
  logic                  out_load;

  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && (state == ST_IDLE);
  assign is_insert = (in_data.func == FUNC_INSERT);
  assign full      = (count == FULL_COUNT);

  // shared compare unit: candidate from RAM against the running best
  assign cand         = entry_t'(ram_rdata);
  assign take_cand    = (rd_idx == '0) || entry_before(cand, best);
  assign best_cur     = take_cand ? cand : best;
  assign best_idx_cur = take_cand ? rd_idx : best_idx;
  assign scan_last    = ((CW'(rd_idx) + CW'(1)) == count);

  // insert appends at the count; pop moves the last entry into the hole
  // (the last entry is the one read on the final scan cycle)
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = {in_data.key_value, in_data.source_lane};
    ram_raddr = '0;
    if (state == ST_SCAN) begin
      ram_raddr = rd_idx + AW'(1);
      ram_waddr = best_idx_cur;
      ram_wdata = cand;
      ram_we    = scan_last;
    end else if (in_take && is_insert && !full) begin
      ram_we = 1'b1;
    end
  end

  kwmh_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (LANES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_load = (state == ST_RESP) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // a word taken this edge frees the register unless a new one loads
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (is_insert) begin
              state <= ST_RESP;
              if (full) begin
                res <= '{min_value: '0, min_lane: '0, status: STAT_FULL_DROP,
                         queue_empty: (count == '0)};
              end else begin
                count <= count + CW'(1);
                res   <= '{min_value: '0, min_lane: '0, status: STAT_INSERTED,
                           queue_empty: 1'b0};
              end
            end else if (count == '0) begin
              state <= ST_RESP;
              res   <= '{min_value: '0, min_lane: '0, status: STAT_POP_EMPTY,
                         queue_empty: 1'b1};
            end else begin
              // entry 0 read is already in flight
              rd_idx <= '0;
              state  <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          best     <= best_cur;
          best_idx <= best_idx_cur;
          rd_idx   <= rd_idx + AW'(1);
          if (scan_last) begin
            count <= count - CW'(1);
            res   <= '{min_value: best_cur.value, min_lane: best_cur.lane,
                       status: STAT_POPPED, queue_empty: (count == CW'(1))};
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_load) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/kwmh_checker.sv =====
// Port-level checker for the k-way merge heap core, with its bind.
`default_nettype none
module kwmh_checker
  import kwmh_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_word_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset left work pending");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == STAT_POP_EMPTY) |->
      (out_data.min_value == '0) && (out_data.min_lane == '0) && out_data.queue_empty)
    else $error("bad empty-pop result");

  a_insert_res: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((out_data.status == STAT_INSERTED) || (out_data.status == STAT_FULL_DROP))
      |-> (out_data.min_value == '0) && (out_data.min_lane == '0) && !out_data.queue_empty)
    else $error("bad insert result");

endmodule

bind k_way_merge_min_heap_core kwmh_checker u_kwmh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
